FILE: src/ist_pkg.sv
// ist_pkg: shared constants of the interval set table.
// Command codes and default sizes. No dependencies.
package ist_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_ERASE    = 2'd1;
    localparam logic [1:0] CMD_CONTAINS = 2'd2;
    localparam logic [1:0] CMD_MEX      = 2'd3;

    // status codes carried in m_tuser
    localparam logic STAT_DONE     = 1'b0;
    localparam logic STAT_OVERFLOW = 1'b1;

    // fixed field widths of the stream payload
    localparam int FIELD_W = 32;
    localparam int TOTAL_W = 7;

    // default sizes
    localparam int MAX_INTERVALS_DEF = 64;
    localparam int VALUE_BITS_DEF    = 32;

endpackage

FILE: src/ist_bank.sv
// ist_bank: one bank of interval storage, low and high ends side by side.
// One write port, one read port with registered read data. Uses ist_pkg.
module ist_bank
    import ist_pkg::*;
#(
    parameter int DEPTH = MAX_INTERVALS_DEF,
    parameter int W     = 2 * VALUE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/interval_set_table.sv
// interval_set_table: top level, sequencer and shared compare/push unit.
// Uses ist_pkg and two ist_bank instances (ping-pong interval tables).
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tuser command, s_tdata range_lo, range_hi
//  m       | out | m_tvalid/m_tready  | m_tdata results, m_tuser status
//
// Range commands read the current bank one interval at a time and write the
// rebuilt table into the other bank; commit flips the bank select, or flags overflow.
// Each stored interval is read from the bank and then compared in turn, and a
// split interval or the placing of the merged range takes an extra push step;
// the single read port of the bank and one shared compare unit keep it serial.
// Queries stop at the first covering interval. Reset clears count and totals.
// s_tready is high only while idle; a result waits in the output register.
module interval_set_table
    import ist_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [31:0] range_lo, [63:32] range_hi
    input  logic [1:0]  s_tuser,  // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // [0] is_covered, [32:1] mex_value,
                                  // [39:33] interval_total, [71:40] covered_total
    output logic        m_tuser   // [0] status
);

    localparam int VB = VALUE_BITS;
    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int NW = $clog2(MAX_INTERVALS + 3);
    localparam int EW = (VB > FIELD_W) ? VB : FIELD_W;
    localparam int TW = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam logic [VB-1:0] VAL_TOP = {{(VB-1){1'b1}}, 1'b0};

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_PROC   = 3'd2;
    localparam logic [2:0] ST_PUSH2  = 3'd3;
    localparam logic [2:0] ST_FINAL  = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [VB-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [VB-1:0] ml_reg, ml_next, mh_reg, mh_next;
    logic [VB-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [VB-1:0] mex_reg, mex_next;
    logic          placed_reg, placed_next;
    logic          found_reg, found_next;
    logic          stat_reg, stat_next;
    logic [CW-1:0] i_reg, i_next;
    logic [NW-1:0] n_reg, n_next;
    logic [VB-1:0] sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;
    logic [VB-1:0] total_reg, total_next;
    logic          cur_reg, cur_next;
    logic          out_valid_reg, out_valid_next;
    logic [71:0]   out_data_reg, out_data_next;
    logic          out_stat_reg, out_stat_next;

    logic          s_fire;
    logic          rd_en;
    logic [2*VB-1:0] rdata0, rdata1, rdata;
    logic [VB-1:0] ra, rb;
    logic          push_en;
    logic [VB-1:0] push_a, push_b;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] lo_ext, hi_ext;
    logic [VB-1:0] lo_sat, hi_sat;
    logic          last_item;
    logic [EW-1:0] mex_ext, total_ext;
    logic [TW-1:0] count_ext;
    logic          is_range;

    // saturate incoming ends to the top storable value
    always_comb
    begin
        lo_ext = EW'(s_tdata[31:0]);
        hi_ext = EW'(s_tdata[63:32]);
        lo_sat = (lo_ext > EW'(VAL_TOP)) ? VAL_TOP : lo_ext[VB-1:0];
        hi_sat = (hi_ext > EW'(VAL_TOP)) ? VAL_TOP : hi_ext[VB-1:0];
    end

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign is_range = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_ERASE);

    // two banks: read the current one, rebuild into the other
    assign rd_en   = (state_reg == ST_READ);
    assign wr_en   = push_en && (n_reg < NW'(MAX_INTERVALS));
    assign wr_addr = n_reg[AW-1:0];

    ist_bank #(.DEPTH(MAX_INTERVALS), .W(2 * VB)) u_bank0 (
        .clk   (clk),
        .we    (wr_en && cur_reg),
        .waddr (wr_addr),
        .wdata ({push_b, push_a}),
        .re    (rd_en && !cur_reg),
        .raddr (i_reg[AW-1:0]),
        .rdata (rdata0)
    );

    ist_bank #(.DEPTH(MAX_INTERVALS), .W(2 * VB)) u_bank1 (
        .clk   (clk),
        .we    (wr_en && !cur_reg),
        .waddr (wr_addr),
        .wdata ({push_b, push_a}),
        .re    (rd_en && cur_reg),
        .raddr (i_reg[AW-1:0]),
        .rdata (rdata1)
    );

    assign rdata     = cur_reg ? rdata1 : rdata0;
    assign ra        = rdata[VB-1:0];
    assign rb        = rdata[2*VB-1:VB];
    assign last_item = ((CW + 1)'(i_reg) + 1'b1) == (CW + 1)'(count_reg);

    // output packing
    always_comb
    begin
        mex_ext   = EW'(found_reg ? mex_reg : lo_reg);
        total_ext = EW'(total_next);
        count_ext = TW'(count_next);
    end

    // sequencer and shared compare/push unit
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ml_next        = ml_reg;
        mh_next        = mh_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        mex_next       = mex_reg;
        placed_next    = placed_reg;
        found_next     = found_reg;
        stat_next      = stat_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_stat_next  = out_stat_reg;
        push_en        = 1'b0;
        push_a         = ra;
        push_b         = rb;

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next    = s_tuser;
                    lo_next     = lo_sat;
                    hi_next     = hi_sat;
                    ml_next     = lo_sat;
                    mh_next     = hi_sat;
                    placed_next = 1'b0;
                    found_next  = 1'b0;
                    stat_next   = STAT_DONE;
                    i_next      = '0;
                    n_next      = '0;
                    sum_next    = '0;
                    if (((s_tuser == CMD_INSERT) || (s_tuser == CMD_ERASE))
                        && (lo_sat > hi_sat))
                    begin
                        state_next = ST_OUT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_PROC;
            end

            ST_PROC:
            begin
                state_next = last_item ? ST_FINAL : ST_READ;
                i_next     = i_reg + 1'b1;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (rb + 1'b1 < lo_reg)
                        begin
                            push_en = 1'b1;
                        end
                        else if (ra > hi_reg + 1'b1)
                        begin
                            push_en = 1'b1;
                            if (!placed_reg)
                            begin
                                push_a      = ml_reg;
                                push_b      = mh_reg;
                                placed_next = 1'b1;
                                pa_next     = ra;
                                pb_next     = rb;
                                i_next      = i_reg;
                                state_next  = ST_PUSH2;
                            end
                        end
                        else
                        begin
                            if (ra < ml_reg)
                            begin
                                ml_next = ra;
                            end
                            if (rb > mh_reg)
                            begin
                                mh_next = rb;
                            end
                        end
                    end
                    CMD_ERASE:
                    begin
                        if ((rb < lo_reg) || (ra > hi_reg))
                        begin
                            push_en = 1'b1;
                        end
                        else if (ra < lo_reg)
                        begin
                            push_en = 1'b1;
                            push_b  = lo_reg - 1'b1;
                            if (rb > hi_reg)
                            begin
                                pa_next    = hi_reg + 1'b1;
                                pb_next    = rb;
                                i_next     = i_reg;
                                state_next = ST_PUSH2;
                            end
                        end
                        else if (rb > hi_reg)
                        begin
                            push_en = 1'b1;
                            push_a  = hi_reg + 1'b1;
                        end
                    end
                    CMD_CONTAINS, CMD_MEX:
                    begin
                        if ((ra <= lo_reg) && (lo_reg <= rb))
                        begin
                            found_next = 1'b1;
                            mex_next   = rb + 1'b1;
                            state_next = ST_FINAL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_PUSH2:
            begin
                push_en    = 1'b1;
                push_a     = pa_reg;
                push_b     = pb_reg;
                i_next     = i_reg + 1'b1;
                state_next = last_item ? ST_FINAL : ST_READ;
            end

            ST_FINAL:
            begin
                if ((cmd_reg == CMD_INSERT) && !placed_reg)
                begin
                    push_en     = 1'b1;
                    push_a      = ml_reg;
                    push_b      = mh_reg;
                    placed_next = 1'b1;
                end
                state_next = ST_COMMIT;
            end

            ST_COMMIT:
            begin
                if (is_range)
                begin
                    if (n_reg > NW'(MAX_INTERVALS))
                    begin
                        stat_next = STAT_OVERFLOW;
                    end
                    else
                    begin
                        cur_next   = !cur_reg;
                        count_next = CW'(n_reg);
                        total_next = sum_reg;
                    end
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next        = '0;
                    out_data_next[0]     = found_reg && (cmd_reg == CMD_CONTAINS);
                    out_data_next[32:1]  = (cmd_reg == CMD_MEX) ? mex_ext[31:0] : 32'd0;
                    out_data_next[39:33] = count_ext[TOTAL_W-1:0];
                    out_data_next[71:40] = total_ext[31:0];
                    out_stat_next        = stat_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // shared push counter and coverage sum
        if (push_en)
        begin
            n_next   = n_reg + 1'b1;
            sum_next = sum_reg + (push_b - push_a) + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            cur_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        ml_reg       <= ml_next;
        mh_reg       <= mh_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        mex_reg      <= mex_next;
        placed_reg   <= placed_next;
        found_reg    <= found_next;
        stat_reg     <= stat_next;
        i_reg        <= i_next;
        n_reg        <= n_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;

    // table count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_INTERVALS))
        else $error("interval count above capacity");

    // a new transaction starts a busy period
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("ready while working");

    // the scan only reads stored intervals
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROC) |-> (i_reg < count_reg))
        else $error("scan past table end");

    // the bank flips only on commit
    a_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg != $past(cur_reg)) |-> ($past(state_reg) == ST_COMMIT))
        else $error("bank flip outside commit");

endmodule

FILE: bench/ist_checker.sv
`timescale 1ns / 100ps
// ist_checker: watches both stream channels of interval_set_table, predicts
// each result with its own interval-set model and compares. Depends on ist_pkg.
module ist_checker
    import ist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          overflow_seen
);

    localparam int CAP = MAX_INTERVALS_DEF;
    localparam logic [63:0] TOP = 64'hFFFF_FFFE;

    typedef struct packed {
        logic        covered;
        logic [31:0] mex;
        logic [6:0]  nint;
        logic [31:0] cov_total;
        logic        stat;
    } ist_result_t;

    // model state: sorted disjoint, non-touching intervals
    logic [63:0] set_lo [CAP];
    logic [63:0] set_hi [CAP];
    int          set_n;
    logic [63:0] set_sum;
    ist_result_t expected_q [$];

    function automatic logic [63:0] clamp(logic [31:0] v);
        return (64'(v) > TOP) ? TOP : 64'(v);
    endfunction

    // commit rebuilt table unless it overflows; returns status
    function automatic logic commit(logic [63:0] nl [$], logic [63:0] nh [$]);
        logic [63:0] s;
        s = 0;
        if (nl.size() > CAP)
            return STAT_OVERFLOW;
        foreach (nl[i])
        begin
            set_lo[i] = nl[i];
            set_hi[i] = nh[i];
            s += nh[i] - nl[i] + 1;
        end
        set_n   = nl.size();
        set_sum = s;
        return STAT_DONE;
    endfunction

    function automatic int find_cover(logic [63:0] v);
        for (int i = 0; i < set_n; i++)
            if (set_lo[i] <= v && v <= set_hi[i])
                return i;
        return -1;
    endfunction

    function automatic ist_result_t apply_command(logic [1:0] cmd, logic [31:0] lo_in,
                                                  logic [31:0] hi_in);
        ist_result_t r;
        logic [63:0] lo, hi, ml, mh;
        logic [63:0] nl [$];
        logic [63:0] nh [$];
        logic        placed;
        int          k;
        r  = '0;
        lo = clamp(lo_in);
        hi = clamp(hi_in);
        case (cmd)
            CMD_INSERT:
                if (lo <= hi)
                begin
                    ml = lo;
                    mh = hi;
                    placed = 0;
                    for (int i = 0; i < set_n; i++)
                    begin
                        if (set_hi[i] + 1 < lo)
                        begin
                            nl.push_back(set_lo[i]);
                            nh.push_back(set_hi[i]);
                        end
                        else if (set_lo[i] > hi + 1)
                        begin
                            if (!placed)
                            begin
                                nl.push_back(ml);
                                nh.push_back(mh);
                                placed = 1;
                            end
                            nl.push_back(set_lo[i]);
                            nh.push_back(set_hi[i]);
                        end
                        else
                        begin
                            if (set_lo[i] < ml) ml = set_lo[i];
                            if (set_hi[i] > mh) mh = set_hi[i];
                        end
                    end
                    if (!placed)
                    begin
                        nl.push_back(ml);
                        nh.push_back(mh);
                    end
                    r.stat = commit(nl, nh);
                end
            CMD_ERASE:
                if (lo <= hi)
                begin
                    for (int i = 0; i < set_n; i++)
                    begin
                        if (set_hi[i] < lo || set_lo[i] > hi)
                        begin
                            nl.push_back(set_lo[i]);
                            nh.push_back(set_hi[i]);
                        end
                        else
                        begin
                            if (set_lo[i] < lo)
                            begin
                                nl.push_back(set_lo[i]);
                                nh.push_back(lo - 1);
                            end
                            if (set_hi[i] > hi)
                            begin
                                nl.push_back(hi + 1);
                                nh.push_back(set_hi[i]);
                            end
                        end
                    end
                    r.stat = commit(nl, nh);
                end
            CMD_CONTAINS:
                r.covered = (find_cover(lo) >= 0);
            default:
            begin
                k = find_cover(lo);
                r.mex = (k >= 0) ? 32'(set_hi[k] + 1) : lo[31:0];
            end
        endcase
        r.nint      = 7'(set_n);
        r.cov_total = set_sum[31:0];
        return r;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        ist_result_t exp_r, got;
        if (!rst_n)
        begin
            set_n = 0;
            set_sum = 0;
            expected_q.delete();
            fail_count <= 0;
            results_seen <= 0;
            overflow_seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[0], m_tdata[32:1], m_tdata[39:33], m_tdata[71:40], m_tuser};
                results_seen <= results_seen + 1;
                if (got.stat == STAT_OVERFLOW)
                    overflow_seen <= overflow_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t: mismatch cov exp %0d act %0d | mex exp %0d act %0d",
                                 $time, exp_r.covered, got.covered, exp_r.mex, got.mex);
                        $display("%0t:   nint exp %0d act %0d | total exp %0d act %0d | st exp %0d act %0d",
                                 $time, exp_r.nint, got.nint, exp_r.cov_total, got.cov_total,
                                 exp_r.stat, got.stat);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_command(s_tuser, s_tdata[31:0], s_tdata[63:32]));
            pending <= expected_q.size();
        end
    end

endmodule

FILE: bench/tb_interval_set_table.sv
`timescale 1ns / 100ps
// tb_interval_set_table: stimulus and verdict for interval_set_table.
// Depends on ist_pkg, the block and ist_checker.
module tb_interval_set_table;
    import ist_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;
    int          fail_count, pending, results_seen, overflow_seen;
    int          idle_cycles;
    bit          quiet_phase;
    bit          hold_sink;
    int          item_total;

    interval_set_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    ist_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .overflow_seen(overflow_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result sink: random stall bursts, one long hold-off, none at the end
    initial
    begin
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_sink = 0;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // offer one command and wait for its acceptance
    task automatic send_cmd(logic [1:0] cmd, logic [31:0] lo, logic [31:0] hi);
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {hi, lo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item_total++;
    endtask

    // value drawn mostly from a narrow window so intervals interact
    function automatic logic [31:0] pick_value(logic [31:0] base);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: return base + $urandom_range(0, 300);
        endcase
    endfunction

    initial
    begin
        logic [31:0] base, a, b;
        logic [1:0]  cmd;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_INSERT;
        quiet_phase = 0;
        hold_sink = 0;
        item_total = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table queries, extremes, saturation, touching merge
        send_cmd(CMD_CONTAINS, 32'd0, 32'd0);
        send_cmd(CMD_MEX, 32'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 32'd10, 32'd5);
        send_cmd(CMD_ERASE, 32'd10, 32'd5);
        send_cmd(CMD_INSERT, 32'd0, 32'd0);
        send_cmd(CMD_INSERT, 32'd1, 32'd4);
        send_cmd(CMD_INSERT, 32'd6, 32'd9);
        send_cmd(CMD_MEX, 32'd0, 32'd0);
        send_cmd(CMD_INSERT, 32'd5, 32'd5);
        send_cmd(CMD_MEX, 32'd3, 32'd0);
        send_cmd(CMD_ERASE, 32'd3, 32'd3);
        send_cmd(CMD_CONTAINS, 32'd3, 32'd0);
        send_cmd(CMD_CONTAINS, 32'd4, 32'd0);
        send_cmd(CMD_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_cmd(CMD_MEX, 32'hFFFF_FFFF, 32'd0);
        send_cmd(CMD_CONTAINS, 32'hFFFF_FFFE, 32'd0);
        send_cmd(CMD_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_MEX, 32'd77, 32'd0);
        send_cmd(CMD_ERASE, 32'h5555_5555, 32'hAAAA_AAAA);
        send_cmd(CMD_ERASE, 32'd0, 32'hFFFF_FFFF);
        // fill past capacity with isolated points to provoke overflow
        for (int i = 0; i < 66; i++)
            send_cmd(CMD_INSERT, 32'(i * 4), 32'(i * 4));
        send_cmd(CMD_ERASE, 32'd1, 32'd1);
        send_cmd(CMD_ERASE, 32'd8, 32'd8);
        send_cmd(CMD_ERASE, 32'd9, 32'd10);

        // random part; one long sink hold-off early on
        base = 0;
        for (int n = 0; n < 1500; n++)
        begin
            if (n == 100)
                hold_sink = 1;
            if (n == 1300)
                quiet_phase = 1;
            if (n % 200 == 0)
                base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FC00 : $urandom;
            cmd = 2'($urandom_range(0, 3));
            a = pick_value(base);
            b = ($urandom_range(0, 5) == 0) ? pick_value(base) : a + $urandom_range(0, 12);
            if (cmd == CMD_ERASE && $urandom_range(0, 1))
                b = a + $urandom_range(0, 3);
            send_cmd(cmd, a, b);
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Ran %0d commands: %0d results checked, %0d rejected for overflow.",
                 item_total, results_seen, overflow_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
